@@ rtl/scft_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scft_pkg: shared types and constants of the file table
// Field widths, operation and status codes, and the request and result
// records passed between the front end and the sequencer.
// ----------------------------------------------------------------------------
package scft_pkg;

  localparam int BYTE_W     = 8;
  localparam int NAME_BYTES = 8;
  localparam int DATA_BYTES = 8;
  localparam int NAME_W     = NAME_BYTES * BYTE_W;
  localparam int DATA_W     = DATA_BYTES * BYTE_W;
  localparam int FUNC_W     = 2;
  localparam int LEN_W      = 4;
  localparam int IDX_W      = 4;
  localparam int STATUS_W   = 3;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_WRITE  = 2'd0,
    FUNC_READ   = 2'd1,
    FUNC_REMOVE = 2'd2,
    FUNC_LIST   = 2'd3
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_NODIR     = 3'd1,
    ST_NOCLUSTER = 3'd2,
    ST_NOTFOUND  = 3'd3,
    ST_EMPTY     = 3'd4
  } status_e;

  // Request after name normalisation, length saturation and data masking
  typedef struct packed {
    func_e             func;
    logic [NAME_W-1:0] name;
    logic [DATA_W-1:0] data;
    logic [LEN_W-1:0]  len;
  } req_t;

  typedef struct packed {
    status_e           status;
    logic [IDX_W-1:0]  entry_index;
    logic [IDX_W-1:0]  data_cluster;
    logic [NAME_W-1:0] entry_name;
    logic [DATA_W-1:0] entry_data;
    logic [LEN_W-1:0]  entry_len;
    logic              last;
  } res_t;

endpackage

@@ rtl/scft_in_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scft_in_if: command channel
// Valid/ready channel carrying one file table command per beat.
// ----------------------------------------------------------------------------
interface scft_in_if;
  logic                        valid;
  logic                        ready;
  logic [scft_pkg::FUNC_W-1:0] func;
  logic [scft_pkg::NAME_W-1:0] file_name;
  logic [scft_pkg::DATA_W-1:0] file_data;
  logic [scft_pkg::LEN_W-1:0]  file_len;

  modport source (output valid, func, file_name, file_data, file_len, input ready);
  modport sink   (input valid, func, file_name, file_data, file_len, output ready);
endinterface

@@ rtl/scft_out_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scft_out_if: result channel
// Valid/ready channel carrying one file table result per beat.
// ----------------------------------------------------------------------------
interface scft_out_if;
  logic                          valid;
  logic                          ready;
  logic [scft_pkg::STATUS_W-1:0] status;
  logic [scft_pkg::IDX_W-1:0]    entry_index;
  logic [scft_pkg::IDX_W-1:0]    data_cluster;
  logic [scft_pkg::NAME_W-1:0]   entry_name;
  logic [scft_pkg::DATA_W-1:0]   entry_data;
  logic [scft_pkg::LEN_W-1:0]    entry_len;
  logic                          last;

  modport source (output valid, status, entry_index, data_cluster, entry_name,
                  entry_data, entry_len, last, input ready);
  modport sink   (input valid, status, entry_index, data_cluster, entry_name,
                  entry_data, entry_len, last, output ready);
endinterface

@@ rtl/scft_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scft_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module scft_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/scft_seq.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scft_seq: command sequencer of the file table
// Walks the directory and cluster map one index at a time with a shared
// counter and name comparator, owns the directory and cluster RAMs, and
// holds the result register.
// ----------------------------------------------------------------------------
module scft_seq #(
  parameter int DIR_ENTRIES = 16,
  parameter int CLUSTERS    = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           req_valid_i,
  output logic           req_ready_o,
  input  scft_pkg::req_t req_i,
  output logic           res_valid_o,
  input  logic           res_ready_i,
  output scft_pkg::res_t res_o
);

  localparam int DAW      = (DIR_ENTRIES > 1) ? $clog2(DIR_ENTRIES) : 1;
  localparam int CAW      = (CLUSTERS > 1) ? $clog2(CLUSTERS) : 1;
  localparam int SCAN_MAX = (DIR_ENTRIES > CLUSTERS) ? DIR_ENTRIES : CLUSTERS;
  localparam int SW       = $clog2(SCAN_MAX + 1);
  localparam int OW       = $clog2(DIR_ENTRIES + 1);
  localparam int DIR_W    = scft_pkg::NAME_W + scft_pkg::LEN_W + CAW;
  localparam logic [SW-1:0] DIR_END = SW'(DIR_ENTRIES);
  localparam logic [SW-1:0] CLU_END = SW'(CLUSTERS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_WR_SLOT,
    S_WR_CLU,
    S_DIR_SCAN,
    S_DIR_CMP,
    S_FETCH,
    S_EMIT
  } state_e;

  state_e                       state_q, state_d;
  logic [SW-1:0]                idx_q, idx_d;
  logic [OW-1:0]                emit_cnt_q, emit_cnt_d;
  logic [OW-1:0]                occ_cnt_q, occ_cnt_d;
  logic [DIR_ENTRIES-1:0]       occupied_q, occupied_d;
  logic [CLUSTERS-1:0]          used_q, used_d;
  logic                         out_valid_q, out_valid_d;

  scft_pkg::req_t               req_q, req_d;
  logic [DAW-1:0]               st_slot_q, st_slot_d;
  logic [CAW-1:0]               st_clu_q, st_clu_d;
  logic [scft_pkg::NAME_W-1:0]  st_name_q, st_name_d;
  logic [scft_pkg::LEN_W-1:0]   st_len_q, st_len_d;
  scft_pkg::status_e            st_status_q, st_status_d;
  logic                         st_last_q, st_last_d;
  scft_pkg::res_t               out_q, out_d;

  logic                         dir_we;
  logic [DIR_W-1:0]             dir_wdata;
  logic [DIR_W-1:0]             dir_rdata;
  logic                         clu_we;
  logic [scft_pkg::DATA_W-1:0]  clu_rdata;

  logic [scft_pkg::NAME_W-1:0]  rd_name;
  logic [scft_pkg::LEN_W-1:0]   rd_len;
  logic [CAW-1:0]               rd_clu;
  logic                         name_hit;
  logic                         out_free;

  assign dir_wdata = {req_q.name, req_q.len, idx_q[CAW-1:0]};
  assign rd_name   = dir_rdata[DIR_W-1 -: scft_pkg::NAME_W];
  assign rd_len    = dir_rdata[CAW +: scft_pkg::LEN_W];
  assign rd_clu    = dir_rdata[CAW-1:0];
  assign name_hit  = (req_q.func == scft_pkg::FUNC_LIST) || (rd_name == req_q.name);
  assign out_free  = !out_valid_q || res_ready_i;

  scft_ram #(
    .WIDTH (DIR_W),
    .DEPTH (DIR_ENTRIES)
  ) u_dir_ram (
    .clk_i   (clk_i),
    .we_i    (dir_we),
    .waddr_i (st_slot_q),
    .wdata_i (dir_wdata),
    .raddr_i (idx_q[DAW-1:0]),
    .rdata_o (dir_rdata)
  );

  scft_ram #(
    .WIDTH (scft_pkg::DATA_W),
    .DEPTH (CLUSTERS)
  ) u_clu_ram (
    .clk_i   (clk_i),
    .we_i    (clu_we),
    .waddr_i (idx_q[CAW-1:0]),
    .wdata_i (req_q.data),
    .raddr_i (st_clu_q),
    .rdata_o (clu_rdata)
  );

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    emit_cnt_d  = emit_cnt_q;
    occ_cnt_d   = occ_cnt_q;
    occupied_d  = occupied_q;
    used_d      = used_q;
    out_valid_d = out_valid_q;
    req_d       = req_q;
    st_slot_d   = st_slot_q;
    st_clu_d    = st_clu_q;
    st_name_d   = st_name_q;
    st_len_d    = st_len_q;
    st_status_d = st_status_q;
    st_last_d   = st_last_q;
    out_d       = out_q;
    dir_we      = 1'b0;
    clu_we      = 1'b0;

    // drop the result once taken
    if (out_valid_q && res_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          req_d       = req_i;
          idx_d       = '0;
          emit_cnt_d  = '0;
          st_last_d   = 1'b1;
          st_status_d = scft_pkg::ST_OK;
          unique case (req_i.func)
            scft_pkg::FUNC_WRITE: begin
              if (req_i.name == '0) begin
                st_status_d = scft_pkg::ST_NOTFOUND;
                state_d     = S_EMIT;
              end else begin
                state_d = S_WR_SLOT;
              end
            end
            scft_pkg::FUNC_READ, scft_pkg::FUNC_REMOVE: begin
              if (req_i.name == '0) begin
                st_status_d = scft_pkg::ST_NOTFOUND;
                state_d     = S_EMIT;
              end else begin
                state_d = S_DIR_SCAN;
              end
            end
            scft_pkg::FUNC_LIST: begin
              if (occ_cnt_q == '0) begin
                st_status_d = scft_pkg::ST_EMPTY;
                state_d     = S_EMIT;
              end else begin
                state_d = S_DIR_SCAN;
              end
            end
          endcase
        end
      end

      S_WR_SLOT: begin
        if (idx_q == DIR_END) begin
          st_status_d = scft_pkg::ST_NODIR;
          state_d     = S_EMIT;
        end else if (!occupied_q[idx_q[DAW-1:0]]) begin
          st_slot_d = idx_q[DAW-1:0];
          idx_d     = '0;
          state_d   = S_WR_CLU;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end

      S_WR_CLU: begin
        if (idx_q == CLU_END) begin
          st_status_d = scft_pkg::ST_NOCLUSTER;
          state_d     = S_EMIT;
        end else if (!used_q[idx_q[CAW-1:0]]) begin
          // commit the file, then read the cluster back for the result
          dir_we                  = 1'b1;
          clu_we                  = 1'b1;
          occupied_d[st_slot_q]   = 1'b1;
          used_d[idx_q[CAW-1:0]]  = 1'b1;
          occ_cnt_d               = occ_cnt_q + 1'b1;
          st_clu_d                = idx_q[CAW-1:0];
          st_name_d               = req_q.name;
          st_len_d                = req_q.len;
          state_d                 = S_FETCH;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end

      S_DIR_SCAN: begin
        if (idx_q == DIR_END) begin
          st_status_d = scft_pkg::ST_NOTFOUND;
          state_d     = S_EMIT;
        end else if (occupied_q[idx_q[DAW-1:0]]) begin
          state_d = S_DIR_CMP;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end

      S_DIR_CMP: begin
        if (name_hit) begin
          st_slot_d = idx_q[DAW-1:0];
          st_clu_d  = rd_clu;
          st_name_d = rd_name;
          st_len_d  = rd_len;
          st_last_d = (req_q.func != scft_pkg::FUNC_LIST) ||
                      (OW'(emit_cnt_q + 1'b1) == occ_cnt_q);
          state_d   = S_FETCH;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = S_DIR_SCAN;
        end
      end

      S_FETCH: begin
        state_d = S_EMIT;
      end

      S_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = '0;
          out_d.status = st_status_q;
          out_d.last   = st_last_q;
          if (st_status_q == scft_pkg::ST_OK) begin
            out_d.entry_index  = scft_pkg::IDX_W'(st_slot_q);
            out_d.data_cluster = scft_pkg::IDX_W'(st_clu_q);
            out_d.entry_name   = st_name_q;
            out_d.entry_data   = clu_rdata;
            out_d.entry_len    = st_len_q;
            if (req_q.func == scft_pkg::FUNC_REMOVE) begin
              occupied_d[st_slot_q] = 1'b0;
              used_d[st_clu_q]      = 1'b0;
              occ_cnt_d             = occ_cnt_q - 1'b1;
            end
          end
          if (st_last_q) begin
            state_d = S_IDLE;
          end else begin
            emit_cnt_d = emit_cnt_q + 1'b1;
            idx_d      = idx_q + 1'b1;
            state_d    = S_DIR_SCAN;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      emit_cnt_q  <= '0;
      occ_cnt_q   <= '0;
      occupied_q  <= '0;
      used_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      emit_cnt_q  <= emit_cnt_d;
      occ_cnt_q   <= occ_cnt_d;
      occupied_q  <= occupied_d;
      used_q      <= used_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q       <= req_d;
    st_slot_q   <= st_slot_d;
    st_clu_q    <= st_clu_d;
    st_name_q   <= st_name_d;
    st_len_q    <= st_len_d;
    st_status_q <= st_status_d;
    st_last_q   <= st_last_d;
    out_q       <= out_d;
  end

  assign req_ready_o = (state_q == S_IDLE);
  assign res_valid_o = out_valid_q;
  assign res_o       = out_q;

endmodule

@@ rtl/single_cluster_file_table.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// single_cluster_file_table: flat file table with one cluster per file
// Directory of named entries, cluster-use map and cluster data store.
// Commands write, read, remove and list files; each file holds one cluster.
// ----------------------------------------------------------------------------
//
//  Channel | Dir | Beat carries                                   | Beats per command
//  --------+-----+------------------------------------------------+---------------------
//  in_i    | in  | func, file_name, file_data, file_len           | 1
//  out_o   | out | status, indexes, name, data, len and last      | 1; list 1..DIR_ENTRIES
//
//  One command at a time; the shared scan counter visits one slot or
//  cluster at a time. Write scans for a free directory slot, then for a
//  free cluster. Read and remove scan the directory and compare the name at
//  each occupied slot. List emits one beat per occupied entry in slot order;
//  an empty table answers with the empty status and no scan.
//  Reset clears the occupancy and cluster-use maps at once; no clearing pass.
//  A held result does not block the next command from being taken; a stalled
//  output holds the sequencer in its emit step until the beat is taken.
//
module single_cluster_file_table #(
  parameter int DIR_ENTRIES   = 16,
  parameter int CLUSTERS      = 16,
  parameter int NAME_CHARS    = 8,
  parameter int CLUSTER_BYTES = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  scft_in_if.sink    in_i,
  scft_out_if.source out_o
);

  scft_pkg::req_t               req;
  scft_pkg::res_t               res;
  logic                         res_valid;
  logic                         name_alive;
  logic [scft_pkg::NAME_W-1:0]  name_norm;
  logic [scft_pkg::LEN_W-1:0]   len_sat;
  logic [scft_pkg::DATA_W-1:0]  data_masked;

  // Keep the name up to NAME_CHARS bytes and cut it at its first zero byte
  always_comb begin
    name_norm  = '0;
    name_alive = 1'b1;
    for (int i = 0; i < scft_pkg::NAME_BYTES; i++) begin
      if (name_alive && (i < NAME_CHARS) &&
          (in_i.file_name[scft_pkg::BYTE_W*i +: scft_pkg::BYTE_W] != '0)) begin
        name_norm[scft_pkg::BYTE_W*i +: scft_pkg::BYTE_W] =
          in_i.file_name[scft_pkg::BYTE_W*i +: scft_pkg::BYTE_W];
      end else begin
        name_alive = 1'b0;
      end
    end
  end

  // Saturate the length to one cluster
  assign len_sat = (in_i.file_len > scft_pkg::LEN_W'(CLUSTER_BYTES)) ?
                   scft_pkg::LEN_W'(CLUSTER_BYTES) : in_i.file_len;

  // Zero the data bytes beyond the stored length
  always_comb begin
    for (int i = 0; i < scft_pkg::DATA_BYTES; i++) begin
      data_masked[scft_pkg::BYTE_W*i +: scft_pkg::BYTE_W] =
        (scft_pkg::LEN_W'(i) < len_sat) ?
        in_i.file_data[scft_pkg::BYTE_W*i +: scft_pkg::BYTE_W] : '0;
    end
  end

  assign req.func = scft_pkg::func_e'(in_i.func);
  assign req.name = name_norm;
  assign req.data = data_masked;
  assign req.len  = len_sat;

  scft_seq #(
    .DIR_ENTRIES (DIR_ENTRIES),
    .CLUSTERS    (CLUSTERS)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (in_i.valid),
    .req_ready_o (in_i.ready),
    .req_i       (req),
    .res_valid_o (res_valid),
    .res_ready_i (out_o.ready),
    .res_o       (res)
  );

  // Result beat straight from the sequencer's output register
  assign out_o.valid        = res_valid;
  assign out_o.status       = res.status;
  assign out_o.entry_index  = res.entry_index;
  assign out_o.data_cluster = res.data_cluster;
  assign out_o.entry_name   = res.entry_name;
  assign out_o.entry_data   = res.entry_data;
  assign out_o.entry_len    = res.entry_len;
  assign out_o.last         = res.last;

endmodule
